// ----- src/srq_pkg.sv -----
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and constants of the slot reservation block.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int NUM_QUOTA_REGS = 6;
    localparam int QUOTA_W        = 5;
    localparam int CFG_IDX_W      = 3;
    localparam int LIMIT_W        = 8;
    localparam int CMP_W          = 8;
    localparam logic [CMP_W-1:0] HOUR_LIMIT = 8'd23;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_OFFER   = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_BAD       = 3'd1,
        ST_NO_QUOTA  = 3'd2,
        ST_OVERLAP   = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_RESTARTED = 3'd5
    } status_t;

    typedef logic [NUM_QUOTA_REGS-1:0][QUOTA_W-1:0] quota_arr_t;

    typedef struct packed {
        logic       operation;
        logic [4:0] start_hour;
        logic [4:0] end_hour;
        logic [2:0] category;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic       done_res;
        logic [4:0] films_scheduled;
        logic [4:0] hours_filled;
    } rsp_t;

endpackage

// ----- src/srq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// srq_cfg_regs
// Per-category quota registers, written through the configuration port.
// ----------------------------------------------------------------------------
module srq_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [srq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srq_pkg::QUOTA_W-1:0]         cfg_wdata,
    output srq_pkg::quota_arr_t                 quota_cfg
);

    srq_pkg::quota_arr_t quota_reg;
    srq_pkg::quota_arr_t quota_next;

    always_comb begin
        quota_next = quota_reg;
        for (int k = 0; k < srq_pkg::NUM_QUOTA_REGS; k++) begin
            if (cfg_we && (cfg_index == srq_pkg::CFG_IDX_W'(k))) begin
                quota_next[k] = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_reg <= '0;
        end else begin
            quota_reg <= quota_next;
        end
    end

    assign quota_cfg = quota_reg;

endmodule

// ----- src/srq_sched.sv -----
// ----------------------------------------------------------------------------
// srq_sched
// Schedule state and combinational admission check for one request.
// ----------------------------------------------------------------------------
module srq_sched #(
    parameter int NUM_SLOTS      = 24,
    parameter int NUM_CATEGORIES = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  srq_pkg::req_t       req,
    input  srq_pkg::quota_arr_t quota_cfg,
    output srq_pkg::rsp_t       rsp
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = srq_pkg::CMP_W;

    logic [NUM_SLOTS-1:0]                                occ_reg, occ_next;
    logic [NUM_CATEGORIES-1:0][srq_pkg::QUOTA_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]                                    film_reg, film_next;
    logic [CNT_W-1:0]                                    hour_reg, hour_next;
    logic [srq_pkg::LIMIT_W-1:0]                         limit_reg, limit_next;

    logic [NUM_SLOTS-1:0]            span;
    logic [NUM_CATEGORIES-1:0]       cat_hit;
    logic [srq_pkg::LIMIT_W-1:0]     limit_sum;
    logic [4:0]                      span_len;
    logic                            done_now;
    logic                            bad;
    logic                            no_quota;
    logic                            overlap;
    logic [CMP_W-1:0]                film_ext;
    logic [CMP_W-1:0]                hour_ext;
    srq_pkg::status_t                status;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            span[i] = (CMP_W'(i) >= CMP_W'(req.start_hour)) &&
                      (CMP_W'(i) < CMP_W'(req.end_hour));
        end
        no_quota = 1'b0;
        for (int k = 0; k < NUM_CATEGORIES; k++) begin
            cat_hit[k] = (req.category == 3'(k + 1));
            if (cat_hit[k] && (rem_reg[k] == '0)) begin
                no_quota = 1'b1;
            end
        end
        limit_sum = '0;
        for (int k = 0; k < NUM_CATEGORIES; k++) begin
            limit_sum = limit_sum + srq_pkg::LIMIT_W'(quota_cfg[k]);
        end
    end

    assign span_len = req.end_hour - req.start_hour;
    assign done_now = (CMP_W'(hour_reg) == srq_pkg::HOUR_LIMIT) ||
                      (CMP_W'(film_reg) == CMP_W'(limit_reg));
    assign bad      = (req.start_hour >= req.end_hour) ||
                      (CMP_W'(req.end_hour) > CMP_W'(NUM_SLOTS)) ||
                      (req.category == 3'd0) ||
                      (CMP_W'(req.category) > CMP_W'(NUM_CATEGORIES));
    assign overlap  = |(occ_reg & span);

    always_comb begin
        occ_next   = occ_reg;
        rem_next   = rem_reg;
        film_next  = film_reg;
        hour_next  = hour_reg;
        limit_next = limit_reg;
        if (req.operation == srq_pkg::OP_RESTART) begin
            status     = srq_pkg::ST_RESTARTED;
            occ_next   = '0;
            film_next  = '0;
            hour_next  = '0;
            limit_next = limit_sum;
            for (int k = 0; k < NUM_CATEGORIES; k++) begin
                rem_next[k] = quota_cfg[k];
            end
        end else if (done_now) begin
            status = srq_pkg::ST_IGNORED;
        end else if (bad) begin
            status = srq_pkg::ST_BAD;
        end else if (no_quota) begin
            status = srq_pkg::ST_NO_QUOTA;
        end else if (overlap) begin
            status = srq_pkg::ST_OVERLAP;
        end else begin
            status    = srq_pkg::ST_ACCEPTED;
            occ_next  = occ_reg | span;
            film_next = film_reg + CNT_W'(1);
            hour_next = CNT_W'(CMP_W'(hour_reg) + CMP_W'(span_len));
            for (int k = 0; k < NUM_CATEGORIES; k++) begin
                if (cat_hit[k]) begin
                    rem_next[k] = rem_reg[k] - srq_pkg::QUOTA_W'(1);
                end
            end
        end
    end

    assign film_ext = CMP_W'(film_next);
    assign hour_ext = CMP_W'(hour_next);

    always_comb begin
        rsp.status          = status;
        rsp.done_res        = (hour_ext == srq_pkg::HOUR_LIMIT) ||
                              (film_ext == CMP_W'(limit_next));
        rsp.films_scheduled = film_ext[4:0];
        rsp.hours_filled    = hour_ext[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            rem_reg   <= '0;
            film_reg  <= '0;
            hour_reg  <= '0;
            limit_reg <= '0;
        end else if (fire) begin
            occ_reg   <= occ_next;
            rem_reg   <= rem_next;
            film_reg  <= film_next;
            hour_reg  <= hour_next;
            limit_reg <= limit_next;
        end
    end

`ifndef SYNTHESIS
    a_hours_match_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_reg) == int'(hour_reg))
        else $error("hour count differs from occupied slot count");

    a_films_le_hours: assert property (@(posedge aclk) disable iff (!aresetn)
        film_reg <= hour_reg)
        else $error("more films than occupied hours");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (req.operation == srq_pkg::OP_RESTART) |=>
        (occ_reg == '0) && (film_reg == '0) && (hour_reg == '0))
        else $error("restart did not clear the schedule");
`endif

endmodule

// ----- src/slot_reservation_with_quotas.sv -----
// ----------------------------------------------------------------------------
// slot_reservation_with_quotas
// Greedy interval admission into a day of hour slots with category quotas.
// ----------------------------------------------------------------------------
// Each request either restarts the schedule, reloading quotas from the six
// quota registers, or offers an interval that is checked and, if it passes,
// admitted. The block takes one request per clock while the output is not
// stalled, and returns exactly one response per request. A request waits in
// the request register until the output is free; the admission stage between
// the request register and the response register then updates the slot map
// and its response is registered in the response register.
// Quota writes take effect at the next restart; after reset the block reports
// done and ignores offers until a restart.
// ----------------------------------------------------------------------------
module slot_reservation_with_quotas #(
    parameter int NUM_SLOTS      = 24,
    parameter int NUM_CATEGORIES = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  srq_pkg::req_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output srq_pkg::rsp_t                 m_data,
    input  logic                          cfg_we,
    input  logic [srq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srq_pkg::QUOTA_W-1:0]   cfg_wdata
);

    srq_pkg::quota_arr_t quota_cfg;
    srq_pkg::req_t       in_data_reg;
    srq_pkg::rsp_t       out_data_reg;
    srq_pkg::rsp_t       rsp;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance;

    srq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .quota_cfg (quota_cfg)
    );

    srq_sched #(
        .NUM_SLOTS      (NUM_SLOTS),
        .NUM_CATEGORIES (NUM_CATEGORIES)
    ) u_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .req       (in_data_reg),
        .quota_cfg (quota_cfg),
        .rsp       (rsp)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
